// ----- design/lpmc_pkg.sv -----
// Package for the LED pattern mode controller.
// Holds sizes, codes, the result record and small helper functions.
// No dependencies.
package lpmc_pkg;

  // Sizes of the event queue and the LED row.
  localparam int QUEUE_DEPTH = 32;
  localparam int NUM_LEDS    = 4;

  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W    = $clog2(NUM_LEDS);
  localparam int EVENT_W  = 2;
  localparam int DEB_W    = 10;
  localparam int PERIOD_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] ELAPSED_MAX = '1;
  localparam logic [DEB_W-1:0]    SINCE_MAX   = '1;
  localparam logic [NUM_LEDS-1:0] LED_ALL     = '1;

  // Reset values of the configuration registers.
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST = 10'd50;
  localparam logic [PERIOD_W-1:0] FORWARD_RST  = 16'd200;
  localparam logic [PERIOD_W-1:0] BLINK_RST    = 16'd300;
  localparam logic [PERIOD_W-1:0] BACKWARD_RST = 16'd100;

  // Reset positions of the running lights.
  localparam logic [POS_W-1:0] FWD_POS_RST = POS_W'(1 % NUM_LEDS);
  localparam logic [POS_W-1:0] BWD_POS_RST = POS_W'(NUM_LEDS - 1);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(NUM_LEDS - 1);

  // Display modes.
  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_BLINK    = 2'd1,
    MODE_BACKWARD = 2'd2
  } mode_t;

  // Button codes as carried on the input and stored in the queue.
  localparam logic [EVENT_W-1:0] BTN_NEXT = 2'd0;
  localparam logic [EVENT_W-1:0] BTN_PREV = 2'd1;
  localparam logic [EVENT_W-1:0] BTN_KEEP = 2'd2;
  // Button code that the controller ignores.
  localparam logic [EVENT_W-1:0] BTN_NONE = 2'd3;
  localparam int NUM_BUTTONS = 3;

  // Input action codes.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_PRESS = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKWARD = 2'd3;

  // One result item.
  typedef struct packed {
    logic [NUM_LEDS-1:0] leds;
    logic [1:0]          mode;
    logic                press_accepted;
    logic                event_dropped;
    logic [FILL_W-1:0]   queued_events;
  } result_t;

  // Per-cell control of the queue row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Mode after a queued button event is applied.
  function automatic mode_t next_mode(input mode_t cur, input logic [EVENT_W-1:0] ev);
    mode_t m;
    mode_t r;
    begin
      m = (cur == MODE_FORWARD || cur == MODE_BLINK) ? cur : MODE_BACKWARD;
      r = m;
      if (ev == BTN_NEXT) begin
        case (m)
          MODE_FORWARD: r = MODE_BLINK;
          MODE_BLINK:   r = MODE_BACKWARD;
          default:      r = MODE_FORWARD;
        endcase
      end else if (ev == BTN_PREV) begin
        case (m)
          MODE_FORWARD: r = MODE_BACKWARD;
          MODE_BLINK:   r = MODE_FORWARD;
          default:      r = MODE_BLINK;
        endcase
      end
      return r;
    end
  endfunction

endpackage

// ----- design/lpmc_channels.sv -----
// Handshake channels of the LED pattern mode controller: input, result and
// configuration write. Depends on lpmc_pkg.
interface lpmc_in_if;
  import lpmc_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [EVENT_W-1:0] button;
  modport source (output valid, action, button, input ready);
  modport sink   (input valid, action, button, output ready);
endinterface

interface lpmc_out_if;
  import lpmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [NUM_LEDS-1:0] leds;
  logic [1:0]          mode;
  logic                press_accepted;
  logic                event_dropped;
  logic [FILL_W-1:0]   queued_events;
  modport source (output valid, leds, mode, press_accepted, event_dropped, queued_events,
                  input ready);
  modport sink   (input valid, leds, mode, press_accepted, event_dropped, queued_events,
                  output ready);
endinterface

interface lpmc_cfg_if;
  import lpmc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/lpmc_queue_cell.sv -----
// One cell of the shift-register event queue.
// Depends on lpmc_pkg.
module lpmc_queue_cell (
  input  logic                        clk,
  input  lpmc_pkg::cell_ctrl_t        ctrl,
  input  logic [lpmc_pkg::EVENT_W-1:0] from_upper,
  input  logic [lpmc_pkg::EVENT_W-1:0] push_data,
  output logic [lpmc_pkg::EVENT_W-1:0] data
);
  import lpmc_pkg::*;

  // On a pop every cell takes its upper neighbor's event; on a push only
  // the cell at the fill position loads the new event.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= from_upper;
    end else if (ctrl.load) begin
      data <= push_data;
    end
  end

endmodule

// ----- design/lpmc_event_queue.sv -----
// Event queue built as a row of cells that shift toward the head on a pop.
// Depends on lpmc_pkg and lpmc_queue_cell.
module lpmc_event_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [lpmc_pkg::EVENT_W-1:0] push_data,
  input  logic                         pop,
  output logic [lpmc_pkg::EVENT_W-1:0] head,
  output logic [lpmc_pkg::FILL_W-1:0]  fill
);
  import lpmc_pkg::*;

  logic [EVENT_W-1:0] cell_data [QUEUE_DEPTH];
  cell_ctrl_t         ctrl      [QUEUE_DEPTH];
  logic [FILL_W-1:0]  fill_next;

  // Build the row; the top cell takes an empty slot from above.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [EVENT_W-1:0] upper;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end
    assign ctrl[i].shift = pop;
    assign ctrl[i].load  = push && (fill == FILL_W'(i));
    lpmc_queue_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .from_upper (upper),
      .push_data  (push_data),
      .data       (cell_data[i])
    );
  end

  assign head = cell_data[0];

  // Fill count; the caller never pushes a full queue or pops an empty one.
  always_comb begin
    fill_next = fill;
    if (pop) begin
      fill_next = fill - FILL_W'(1);
    end else if (push) begin
      fill_next = fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// ----- design/led_pattern_mode_controller_core.sv -----
// LED pattern mode controller: ticks and button presses in, LED state out.
// Each accepted item yields one registered result; one item per cycle is
// taken while the result side keeps up, and a two-entry output buffer holds
// results when the result side stalls. The event queue is a row of shift cells.
// Reset (synchronous) loads the default periods and debounce, mode forward with
// LED 0 lit, and an empty queue; no clearing pass is needed.
module led_pattern_mode_controller_core (
  input logic       clk,
  input logic       rst,
  lpmc_in_if.sink   in_ch,
  lpmc_out_if.source out_ch,
  lpmc_cfg_if.sink  cfg
);
  import lpmc_pkg::*;

  // Configuration registers.
  logic [DEB_W-1:0]    debounce_ms;
  logic [PERIOD_W-1:0] forward_period_ms;
  logic [PERIOD_W-1:0] blink_period_ms;
  logic [PERIOD_W-1:0] backward_period_ms;

  // Controller state.
  mode_t               current_mode, current_mode_next;
  logic [NUM_LEDS-1:0] led_register, led_register_next;
  logic [POS_W-1:0]    forward_position, forward_position_next;
  logic [POS_W-1:0]    backward_position, backward_position_next;
  logic                blink_lit, blink_lit_next;
  logic [PERIOD_W-1:0] period_elapsed, period_elapsed_next;
  logic [DEB_W-1:0]    since_last_press [NUM_BUTTONS];
  logic [DEB_W-1:0]    since_last_press_next [NUM_BUTTONS];

  // Queue handshake.
  logic               q_push, q_pop;
  logic [EVENT_W-1:0] q_head;
  logic [FILL_W-1:0]  q_fill;

  // Output buffer.
  result_t res;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    in_xfer, out_xfer;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = !skid_valid;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid && out_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= DEBOUNCE_RST;
      forward_period_ms  <= FORWARD_RST;
      blink_period_ms    <= BLINK_RST;
      backward_period_ms <= BACKWARD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE: debounce_ms        <= cfg.data[DEB_W-1:0];
        REG_FORWARD:  forward_period_ms  <= cfg.data[PERIOD_W-1:0];
        REG_BLINK:    blink_period_ms    <= cfg.data[PERIOD_W-1:0];
        REG_BACKWARD: backward_period_ms <= cfg.data[PERIOD_W-1:0];
        default:      debounce_ms        <= debounce_ms;
      endcase
    end
  end

  lpmc_event_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (in_ch.button),
    .pop       (q_pop),
    .head      (q_head),
    .fill      (q_fill)
  );

  // Per-item update: ticks advance the timers and step the pattern at the
  // end of a period; debounced presses enter the queue unless it is full.
  always_comb begin
    logic [PERIOD_W-1:0] elapsed_inc;
    logic [PERIOD_W-1:0] period;
    logic                accepted;
    logic                dropped;
    mode_t               step_mode;

    current_mode_next      = current_mode;
    led_register_next      = led_register;
    forward_position_next  = forward_position;
    backward_position_next = backward_position;
    blink_lit_next         = blink_lit;
    period_elapsed_next    = period_elapsed;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      since_last_press_next[i] = since_last_press[i];
    end
    q_push      = 1'b0;
    q_pop       = 1'b0;
    accepted    = 1'b0;
    dropped     = 1'b0;
    step_mode   = current_mode;
    elapsed_inc = (period_elapsed != ELAPSED_MAX) ? period_elapsed + PERIOD_W'(1)
                                                  : period_elapsed;
    case (current_mode)
      MODE_FORWARD: period = forward_period_ms;
      MODE_BLINK:   period = blink_period_ms;
      default:      period = backward_period_ms;
    endcase

    if (in_xfer) begin
      if (in_ch.action == ACT_TICK) begin
        period_elapsed_next = elapsed_inc;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (since_last_press[i] != SINCE_MAX) begin
            since_last_press_next[i] = since_last_press[i] + DEB_W'(1);
          end
        end
        if (elapsed_inc >= period) begin
          period_elapsed_next = '0;
          if (q_fill != '0) begin
            q_pop     = 1'b1;
            step_mode = next_mode(current_mode, q_head);
          end
          current_mode_next = step_mode;
          // Step the pattern of the resulting mode.
          case (step_mode)
            MODE_FORWARD: begin
              led_register_next     = NUM_LEDS'(1) << forward_position;
              forward_position_next = (forward_position == POS_LAST) ? '0
                                      : forward_position + POS_W'(1);
            end
            MODE_BLINK: begin
              led_register_next = blink_lit ? '0 : LED_ALL;
              blink_lit_next    = !blink_lit;
            end
            default: begin
              led_register_next      = NUM_LEDS'(1) << backward_position;
              backward_position_next = (backward_position == '0) ? POS_LAST
                                       : backward_position - POS_W'(1);
            end
          endcase
        end
      end else if (in_ch.button != BTN_NONE &&
                   since_last_press[in_ch.button] >= debounce_ms) begin
        accepted = 1'b1;
        since_last_press_next[in_ch.button] = '0;
        if (q_fill >= FILL_W'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          q_push = 1'b1;
        end
      end
    end

    res.leds           = led_register_next;
    res.mode           = current_mode_next;
    res.press_accepted = accepted;
    res.event_dropped  = dropped;
    if (q_pop) begin
      res.queued_events = q_fill - FILL_W'(1);
    end else if (q_push) begin
      res.queued_events = q_fill + FILL_W'(1);
    end else begin
      res.queued_events = q_fill;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode      <= MODE_FORWARD;
      led_register      <= NUM_LEDS'(1);
      forward_position  <= FWD_POS_RST;
      backward_position <= BWD_POS_RST;
      blink_lit         <= 1'b0;
      period_elapsed    <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        since_last_press[i] <= '0;
      end
    end else begin
      current_mode      <= current_mode_next;
      led_register      <= led_register_next;
      forward_position  <= forward_position_next;
      backward_position <= backward_position_next;
      blink_lit         <= blink_lit_next;
      period_elapsed    <= period_elapsed_next;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        since_last_press[i] <= since_last_press_next[i];
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_xfer) begin
        out_data <= res;
      end
    end else if (in_xfer) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.leds           = out_data.leds;
  assign out_ch.mode           = out_data.mode;
  assign out_ch.press_accepted = out_data.press_accepted;
  assign out_ch.event_dropped  = out_data.event_dropped;
  assign out_ch.queued_events  = out_data.queued_events;

endmodule

// ----- dv/led_pattern_mode_controller_core_tb.sv -----
// Self-checking testbench for led_pattern_mode_controller_core: a directed table, then
// phases of random ticks and presses under several register settings, with random stalls.
// Depends on lpmc_pkg, the lpmc channel interfaces and the controller core.
module led_pattern_mode_controller_core_tb;
  import lpmc_pkg::*;

  localparam int MAX_REPORTS   = 10;
  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 2000000;
  localparam int ZERO_CFG_ROW  = 3;
  localparam int DIR_COUNT     = 26;
  localparam result_t NO_CHECK = '0;

  typedef struct packed {
    logic               act;
    logic [EVENT_W-1:0] btn;
    logic               has_exp;
    result_t            exp;
  } dir_row_t;

  logic clk;
  logic rst;

  lpmc_in_if  in_ch ();
  lpmc_out_if out_ch ();
  lpmc_cfg_if cfg_ch ();

  led_pattern_mode_controller_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // Directed rows. The first rows run with the reset settings; from ZERO_CFG_ROW on, the
  // debounce and all periods are zero: each tick ends a period, each button press counts.
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{ACT_PRESS, BTN_NEXT, 1'b1, '{4'h1, MODE_FORWARD,  1'b0, 1'b0, 6'd0}},
    '{ACT_PRESS, BTN_NONE, 1'b1, '{4'h1, MODE_FORWARD,  1'b0, 1'b0, 6'd0}},
    '{ACT_TICK,  BTN_NEXT, 1'b1, '{4'h1, MODE_FORWARD,  1'b0, 1'b0, 6'd0}},
    '{ACT_PRESS, BTN_NEXT, 1'b1, '{4'h1, MODE_FORWARD,  1'b1, 1'b0, 6'd1}},
    '{ACT_PRESS, BTN_PREV, 1'b1, '{4'h1, MODE_FORWARD,  1'b1, 1'b0, 6'd2}},
    '{ACT_PRESS, BTN_KEEP, 1'b1, '{4'h1, MODE_FORWARD,  1'b1, 1'b0, 6'd3}},
    '{ACT_PRESS, BTN_NONE, 1'b1, '{4'h1, MODE_FORWARD,  1'b0, 1'b0, 6'd3}},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_PREV, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_KEEP, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NONE, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_PRESS, BTN_PREV, 1'b1, '{4'h1, MODE_FORWARD,  1'b1, 1'b0, 6'd1}},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_PRESS, BTN_NEXT, 1'b1, '{4'h8, MODE_BACKWARD, 1'b1, 1'b0, 6'd1}},
    '{ACT_PRESS, BTN_PREV, 1'b1, '{4'h8, MODE_BACKWARD, 1'b1, 1'b0, 6'd2}},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_PRESS, BTN_PREV, 1'b1, '{4'h4, MODE_BACKWARD, 1'b1, 1'b0, 6'd1}},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK},
    '{ACT_PRESS, BTN_NEXT, 1'b1, '{4'h0, MODE_BLINK,    1'b1, 1'b0, 6'd1}},
    '{ACT_TICK,  BTN_NEXT, 1'b0, NO_CHECK}
  };

  // Register copies and controller state kept by the predictor.
  logic [DEB_W-1:0]    cfg_debounce;
  logic [PERIOD_W-1:0] cfg_forward;
  logic [PERIOD_W-1:0] cfg_blink;
  logic [PERIOD_W-1:0] cfg_backward;
  mode_t               ctl_mode;
  logic [NUM_LEDS-1:0] ctl_leds;
  logic [POS_W-1:0]    fwd_pos;
  logic [POS_W-1:0]    bwd_pos;
  logic                blink_on;
  logic [PERIOD_W-1:0] elapsed;
  logic [DEB_W-1:0]    since_press [NUM_BUTTONS];
  logic [EVENT_W-1:0]  queued_buttons [$];

  // LED states the block still owes, oldest first.
  result_t expected_states [$];

  // Typed expectation that goes with the item on offer, if any.
  logic    row_has_exp = 1'b0;
  result_t row_exp     = '0;

  int error_count   = 0;
  int sink_idle_pct = 0;
  bit long_stall_req  = 1'b0;
  bit long_stall_done = 1'b0;

  // Idle stretches are mostly short, with a few long ones.
  function automatic int gap_cycles();
    return ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // Advance the predicted controller by one tick or press and report its outputs.
  task automatic step_controller(input logic act, input logic [EVENT_W-1:0] btn,
                                 output result_t res);
    logic [PERIOD_W-1:0] period;
    logic [EVENT_W-1:0]  ev;
    logic                accepted;
    logic                dropped;
    begin
      accepted = 1'b0;
      dropped  = 1'b0;
      if (act == ACT_TICK) begin
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + PERIOD_W'(1);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (since_press[b] != SINCE_MAX) since_press[b] = since_press[b] + DEB_W'(1);
        end
        period = (ctl_mode == MODE_FORWARD) ? cfg_forward :
                 (ctl_mode == MODE_BLINK)   ? cfg_blink : cfg_backward;
        if (elapsed >= period) begin
          elapsed = '0;
          // A finished period consumes one queued button, then the pattern steps.
          if (queued_buttons.size() > 0) begin
            ev = queued_buttons.pop_front();
            case (ev)
              BTN_NEXT: begin
                ctl_mode = (ctl_mode == MODE_FORWARD) ? MODE_BLINK :
                           (ctl_mode == MODE_BLINK)   ? MODE_BACKWARD : MODE_FORWARD;
              end
              BTN_PREV: begin
                ctl_mode = (ctl_mode == MODE_FORWARD) ? MODE_BACKWARD :
                           (ctl_mode == MODE_BLINK)   ? MODE_FORWARD : MODE_BLINK;
              end
              default: ;
            endcase
          end
          if (ctl_mode == MODE_FORWARD) begin
            ctl_leds = NUM_LEDS'(1) << fwd_pos;
            fwd_pos  = (fwd_pos == POS_LAST) ? '0 : fwd_pos + POS_W'(1);
          end else if (ctl_mode == MODE_BLINK) begin
            ctl_leds = blink_on ? '0 : LED_ALL;
            blink_on = ~blink_on;
          end else begin
            ctl_leds = NUM_LEDS'(1) << bwd_pos;
            bwd_pos  = (bwd_pos == '0) ? POS_LAST : bwd_pos - POS_W'(1);
          end
        end
      end else if (btn != BTN_NONE && since_press[btn] >= cfg_debounce) begin
        // A debounced press restarts its count even when the queue has no room.
        accepted         = 1'b1;
        since_press[btn] = '0;
        if (queued_buttons.size() >= QUEUE_DEPTH) dropped = 1'b1;
        else queued_buttons.push_back(btn);
      end
      res.leds           = ctl_leds;
      res.mode           = ctl_mode;
      res.press_accepted = accepted;
      res.event_dropped  = dropped;
      res.queued_events  = FILL_W'(queued_buttons.size());
    end
  endtask

  task automatic log_error(input string what, input result_t want, input result_t got);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: %s: expected leds=%h mode=%0d acc=%b drop=%b queued=%0d",
               $time, what, want.leds, want.mode, want.press_accepted, want.event_dropped,
               want.queued_events);
      $display("%0t: %s: got      leds=%h mode=%0d acc=%b drop=%b queued=%0d",
               $time, what, got.leds, got.mode, got.press_accepted, got.event_dropped,
               got.queued_events);
    end
    error_count++;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Predictor and checker: register writes, accepted items and result transfers.
  always @(posedge clk) begin : scoreboard
    result_t predicted;
    result_t got;
    result_t want;
    if (rst) begin
      cfg_debounce = DEBOUNCE_RST;
      cfg_forward  = FORWARD_RST;
      cfg_blink    = BLINK_RST;
      cfg_backward = BACKWARD_RST;
      ctl_mode     = MODE_FORWARD;
      ctl_leds     = NUM_LEDS'(1);
      fwd_pos      = FWD_POS_RST;
      bwd_pos      = BWD_POS_RST;
      blink_on     = 1'b0;
      elapsed      = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) since_press[b] = '0;
      queued_buttons.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DEBOUNCE: cfg_debounce = cfg_ch.data[DEB_W-1:0];
          REG_FORWARD:  cfg_forward  = cfg_ch.data;
          REG_BLINK:    cfg_blink    = cfg_ch.data;
          REG_BACKWARD: cfg_backward = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        step_controller(in_ch.action, in_ch.button, predicted);
        expected_states.push_back(row_has_exp ? row_exp : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.leds           = out_ch.leds;
        got.mode           = out_ch.mode;
        got.press_accepted = out_ch.press_accepted;
        got.event_dropped  = out_ch.event_dropped;
        got.queued_events  = out_ch.queued_events;
        if (expected_states.size() == 0) begin
          log_error("result with nothing outstanding", NO_CHECK, got);
        end else begin
          want = expected_states.pop_front();
          if (got.leds !== want.leds || got.mode !== want.mode ||
              got.press_accepted !== want.press_accepted ||
              got.event_dropped !== want.event_dropped ||
              got.queued_events !== want.queued_events) begin
            log_error("mismatch", want, got);
          end
        end
      end
    end
  end

  // Result side: random stalls, and one long hold-off when requested so the block backs up.
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req && !long_stall_done) begin
        out_ch.ready = 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        long_stall_done = 1'b1;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        out_ch.ready = 1'b0;
        n = gap_cycles();
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offer one item and hold it until its transfer; valid stays high afterwards.
  task automatic send_item(input logic act, input logic [EVENT_W-1:0] btn,
                           input logic has_exp, input result_t exp);
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.action  = act;
    in_ch.button  = btn;
    row_has_exp   = has_exp;
    row_exp       = exp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the pipeline go quiet.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] fwd,
                              input logic [CFG_DATA_W-1:0] blk, input logic [CFG_DATA_W-1:0] bwd);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idxs [4];
    vals = '{deb, fwd, blk, bwd};
    idxs = '{REG_DEBOUNCE, REG_FORWARD, REG_BLINK, REG_BACKWARD};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_ch.valid = 1'b1;
      cfg_ch.index = idxs[k];
      cfg_ch.data  = vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin : stimulus
    int n_items;
    int press_pct;
    int src_idle_pct;
    int n;
    int waited;
    logic                  act;
    logic [EVENT_W-1:0]    btn;
    logic [CFG_DATA_W-1:0] deb;
    logic [CFG_DATA_W-1:0] fwd;
    logic [CFG_DATA_W-1:0] blk;
    logic [CFG_DATA_W-1:0] bwd;

    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.button = BTN_NEXT;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DEBOUNCE;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, first under reset settings, then with zero debounce and periods.
    sink_idle_pct = 20;
    for (int r = 0; r < DIR_COUNT; r++) begin
      if (r == ZERO_CFG_ROW) begin
        settle_block();
        program_regs('0, '0, '0, '0);
      end
      send_item(dir_rows[r].act, dir_rows[r].btn, dir_rows[r].has_exp, dir_rows[r].exp);
    end

    // Random phases: queue overflow, fast mode changes under back-pressure,
    // mixed settings, and the longest debounce, which holds presses off.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          deb = '0; fwd = 16'hFFFF; blk = 16'hFFFF; bwd = 16'hFFFF;
          n_items = 80; press_pct = 90; src_idle_pct = 30; sink_idle_pct = 0;
        end
        1: begin
          deb = 16'd2; fwd = 16'd1; blk = 16'd2; bwd = 16'd3;
          n_items = 220; press_pct = 45; src_idle_pct = 0; sink_idle_pct = 20;
        end
        2: begin
          deb = CFG_DATA_W'($urandom_range(0, 15)) |
                (CFG_DATA_W'($urandom_range(1, 63)) << DEB_W);
          fwd = CFG_DATA_W'($urandom_range(1, 12));
          blk = CFG_DATA_W'($urandom_range(1, 12));
          bwd = CFG_DATA_W'($urandom_range(1, 12));
          n_items = 260; press_pct = 35; src_idle_pct = 25; sink_idle_pct = 25;
        end
        default: begin
          deb = 16'd1023;
          fwd = CFG_DATA_W'($urandom_range(1, 4));
          blk = CFG_DATA_W'($urandom_range(1, 4));
          bwd = CFG_DATA_W'($urandom_range(1, 4));
          n_items = 420; press_pct = 3; src_idle_pct = 10; sink_idle_pct = 10;
        end
      endcase
      settle_block();
      program_regs(deb, fwd, blk, bwd);
      if (ph == 1) long_stall_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(99) < src_idle_pct) begin
          @(negedge clk);
          in_ch.valid = 1'b0;
          n = gap_cycles();
          repeat (n - 1) @(negedge clk);
        end
        act = ($urandom_range(99) < press_pct) ? ACT_PRESS : ACT_TICK;
        btn = ($urandom_range(9) == 0) ? BTN_NONE : EVENT_W'($urandom_range(0, 2));
        send_item(act, btn, 1'b0, NO_CHECK);
      end
    end

    // Wait for the last results, with a limit, then give the verdict.
    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (expected_states.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_states.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_states.size());
      error_count += expected_states.size();
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lpmc_pkg.sv
design/lpmc_channels.sv
design/lpmc_queue_cell.sv
design/lpmc_event_queue.sv
design/led_pattern_mode_controller_core.sv
dv/led_pattern_mode_controller_core_tb.sv
